// ----- rtl/sbus_frame_decoder_defines.svh -----
// ----------------------------------------------------------------------------
// sbus_frame_decoder_defines
// assertion macros used by the frame decoder rtl
// ----------------------------------------------------------------------------
`ifndef SBUS_FRAME_DECODER_DEFINES_SVH
`define SBUS_FRAME_DECODER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SFD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SFD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sfd_pkg.sv -----
// ----------------------------------------------------------------------------
// sfd_pkg
// types and constants of the sbus frame decoder
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int BYTE_W      = 8;
    localparam int CHAN_W      = 11;
    localparam int NUM_CHAN    = 7;
    localparam int FRAME_LEN   = 25;
    localparam int PAYLOAD_LEN = 10;
    localparam int POS_W       = $clog2(FRAME_LEN);

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [POS_W-1:0]  pos_t;

    localparam byte_t START_BYTE_RESET = 8'h0F;
    localparam logic [3:0] END_NIBBLE  = 4'h4;
    localparam pos_t LAST_POS          = POS_W'(FRAME_LEN - 1);
    localparam pos_t FIRST_POS         = POS_W'(1);

endpackage

// ----- rtl/sbus_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// sbus_frame_decoder
// collects 25-byte sbus frames from received bytes and emits channels 0 to 6
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one received serial byte per beat (s_rx_byte).
//   m_ channel: one beat per good frame, carrying channels 0 to 6, 11 bits each.
//   cfg channel: writes the start byte; cfg_ready is always high.
//   While idle, bytes are dropped until one matches the start byte. The next
//   24 bytes complete the frame; frame bytes 1 to 10 are kept in a register
//   file. The last byte must have low nibble 4, otherwise the frame is dropped.
//   Throughput: one byte per cycle; the frame state and decode sit between the
//   payload registers and the single output register.
//   Latency: the result is valid in the cycle after the frame's last byte beat.
//   When the receiver stalls, the result waits in the output register and the
//   input keeps flowing as long as that register is empty or being drained in
//   the same cycle.
//   Reset: start byte returns to 0x0F, decoder goes idle, output goes empty.
//   Payload registers are not reset; each is written before it is read.
// ----------------------------------------------------------------------------
`include "sbus_frame_decoder_defines.svh"

module sbus_frame_decoder (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  sfd_pkg::byte_t       cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sfd_pkg::byte_t       s_rx_byte,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sfd_pkg::chan_t       m_chan_0,
    output sfd_pkg::chan_t       m_chan_1,
    output sfd_pkg::chan_t       m_chan_2,
    output sfd_pkg::chan_t       m_chan_3,
    output sfd_pkg::chan_t       m_chan_4,
    output sfd_pkg::chan_t       m_chan_5,
    output sfd_pkg::chan_t       m_chan_6
);

    localparam int STREAM_W = sfd_pkg::PAYLOAD_LEN * sfd_pkg::BYTE_W;

    sfd_pkg::byte_t start_byte_reg;
    sfd_pkg::pos_t  pos_reg, pos_next;
    logic           in_frame_reg, in_frame_next;
    sfd_pkg::byte_t payload_reg [sfd_pkg::PAYLOAD_LEN];
    logic           m_valid_reg, m_valid_next;
    sfd_pkg::chan_t chan_reg [sfd_pkg::NUM_CHAN];
    sfd_pkg::chan_t chan_next [sfd_pkg::NUM_CHAN];

    logic                s_beat;
    logic                last_byte;
    logic                frame_good;
    logic [STREAM_W-1:0] stream;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_beat    = s_valid && s_ready;
    assign last_byte = in_frame_reg && (pos_reg >= sfd_pkg::LAST_POS);
    assign frame_good = last_byte && (s_rx_byte[3:0] == sfd_pkg::END_NIBBLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_byte_reg <= sfd_pkg::START_BYTE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            start_byte_reg <= cfg_data;
        end
    end

    // frame tracking
    always_comb begin
        pos_next      = pos_reg;
        in_frame_next = in_frame_reg;
        if (s_beat) begin
            if (!in_frame_reg) begin
                if (s_rx_byte == start_byte_reg) begin
                    in_frame_next = 1'b1;
                    pos_next      = sfd_pkg::FIRST_POS;
                end
            end else if (last_byte) begin
                in_frame_next = 1'b0;
                pos_next      = '0;
            end else begin
                pos_next = pos_reg + sfd_pkg::FIRST_POS;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            in_frame_reg <= 1'b0;
        end else begin
            pos_reg      <= pos_next;
            in_frame_reg <= in_frame_next;
        end
    end

    // frame bytes 1 to 10
    always_ff @(posedge aclk) begin
        for (int i = 0; i < sfd_pkg::PAYLOAD_LEN; i++) begin
            if (s_beat && in_frame_reg && pos_reg == sfd_pkg::pos_t'(i + 1)) begin
                payload_reg[i] <= s_rx_byte;
            end
        end
    end

    // little-endian bit stream of the payload, channels are 11-bit slices
    always_comb begin
        for (int i = 0; i < sfd_pkg::PAYLOAD_LEN; i++) begin
            stream[i*sfd_pkg::BYTE_W +: sfd_pkg::BYTE_W] = payload_reg[i];
        end
        for (int k = 0; k < sfd_pkg::NUM_CHAN; k++) begin
            chan_next[k] = stream[k*sfd_pkg::CHAN_W +: sfd_pkg::CHAN_W];
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_beat && frame_good) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat && frame_good) begin
            for (int k = 0; k < sfd_pkg::NUM_CHAN; k++) begin
                chan_reg[k] <= chan_next[k];
            end
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_chan_0 = chan_reg[0];
    assign m_chan_1 = chan_reg[1];
    assign m_chan_2 = chan_reg[2];
    assign m_chan_3 = chan_reg[3];
    assign m_chan_4 = chan_reg[4];
    assign m_chan_5 = chan_reg[5];
    assign m_chan_6 = chan_reg[6];

    `SFD_ASSERT_NOW(a_idle_pos_zero, aclk, aresetn, !in_frame_reg, pos_reg == '0,
        "idle decoder holds a nonzero byte position")

    `SFD_ASSERT_NOW(a_pos_in_range, aclk, aresetn, in_frame_reg,
        (pos_reg >= sfd_pkg::FIRST_POS) && (pos_reg <= sfd_pkg::LAST_POS),
        "byte position out of frame range")

    `SFD_ASSERT_NEXT(a_good_frame_emits, aclk, aresetn, s_beat && frame_good,
        m_valid_reg && !in_frame_reg,
        "good frame did not produce a result")

    `SFD_ASSERT_NEXT(a_no_spurious_result, aclk, aresetn,
        !m_valid_reg && !(s_beat && frame_good), !m_valid_reg,
        "result appeared without a good frame")

endmodule

// ----- bench/sbus_frame_decoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbus_frame_decoder_tb
// Streams received bytes into the frame decoder: a few directed bytes, then
// mostly whole frames with random content, mixed with noise, cut-off frames
// and frames that fail the end check. A predictor tracks the frame state and
// the kept payload bytes and works out the channels of every good frame. The
// monitor compares each result beat with the oldest prediction. The start
// byte is rewritten before four of the phases. The phases vary the pattern of
// sender gaps and receiver stalls, and one phase holds the receiver off long
// enough to back up the input.
// ----------------------------------------------------------------------------
module sbus_frame_decoder_tb;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_LEN       = 400;

    typedef logic [sfd_pkg::NUM_CHAN-1:0][sfd_pkg::CHAN_W-1:0] chan_set_t;

    logic            aclk      = 1'b0;
    logic            aresetn   = 1'b0;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    sfd_pkg::byte_t  cfg_data  = '0;
    logic            s_valid   = 1'b0;
    logic            s_ready;
    sfd_pkg::byte_t  s_rx_byte = '0;
    logic            m_valid;
    logic            m_ready   = 1'b0;
    sfd_pkg::chan_t  m_chan [sfd_pkg::NUM_CHAN];

    // predictor state
    sfd_pkg::byte_t  start_byte_q = sfd_pkg::START_BYTE_RESET;
    logic            in_frame_q   = 1'b0;
    sfd_pkg::pos_t   frame_pos_q  = '0;
    sfd_pkg::byte_t  payload_q [sfd_pkg::PAYLOAD_LEN];

    sfd_pkg::byte_t  rx_q [$];
    chan_set_t       chans_q [$];

    int     send_idle_pct  = 0;
    int     recv_stall_pct = 0;
    logic   hold_req       = 1'b0;
    int     hold_cnt       = 0;
    int     err_count      = 0;
    int     idle_cycles    = 0;

    sbus_frame_decoder u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_chan_0  (m_chan[0]),
        .m_chan_1  (m_chan[1]),
        .m_chan_2  (m_chan[2]),
        .m_chan_3  (m_chan[3]),
        .m_chan_4  (m_chan[4]),
        .m_chan_5  (m_chan[5]),
        .m_chan_6  (m_chan[6])
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // one received byte through the frame state; a good frame yields one result
    function automatic void absorb_rx_byte(input sfd_pkg::byte_t b);
        logic [sfd_pkg::PAYLOAD_LEN*sfd_pkg::BYTE_W-1:0] stream;
        chan_set_t                                       chans;
        if (!in_frame_q) begin
            if (b == start_byte_q) begin
                in_frame_q  = 1'b1;
                frame_pos_q = sfd_pkg::FIRST_POS;
            end
        end else begin
            if (frame_pos_q >= sfd_pkg::FIRST_POS &&
                frame_pos_q <= sfd_pkg::pos_t'(sfd_pkg::PAYLOAD_LEN))
                payload_q[frame_pos_q - sfd_pkg::FIRST_POS] = b;
            if (frame_pos_q >= sfd_pkg::LAST_POS) begin
                in_frame_q  = 1'b0;
                frame_pos_q = '0;
                if (b[3:0] == sfd_pkg::END_NIBBLE) begin
                    // frame bytes 1 to 10 form one little-endian bit stream
                    for (int i = 0; i < sfd_pkg::PAYLOAD_LEN; i++)
                        stream[i*sfd_pkg::BYTE_W +: sfd_pkg::BYTE_W] = payload_q[i];
                    for (int k = 0; k < sfd_pkg::NUM_CHAN; k++)
                        chans[k] = stream[k*sfd_pkg::CHAN_W +: sfd_pkg::CHAN_W];
                    chans_q.push_back(chans);
                end
            end else begin
                frame_pos_q = frame_pos_q + 1'b1;
            end
        end
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                absorb_rx_byte(s_rx_byte);
            if (!s_valid || s_ready) begin
                if (rx_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid   <= 1'b1;
                    s_rx_byte <= rx_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here once requested
    always @(posedge aclk) begin
        if (hold_req && hold_cnt < HOLD_LEN)
            hold_cnt <= hold_cnt + 1;
    end

    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else if (hold_req && hold_cnt < HOLD_LEN)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor
    always @(posedge aclk) begin
        chan_set_t want;
        if (aresetn && m_valid && m_ready) begin
            if (chans_q.size() == 0) begin
                report_mismatch("result beat with no frame pending");
            end else begin
                want = chans_q.pop_front();
                for (int k = 0; k < sfd_pkg::NUM_CHAN; k++) begin
                    if (m_chan[k] !== want[k])
                        report_mismatch($sformatf("chan_%0d got %0d want %0d",
                                                  k, m_chan[k], want[k]));
                end
            end
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  <= send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    task automatic write_start_byte(input sfd_pkg::byte_t value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        start_byte_q = value;
        cfg_valid <= 1'b0;
    endtask

    // wait until all bytes are taken and all results are back
    // checked mid-cycle so the driver's pops and updates have settled
    task automatic drain();
        @(negedge aclk);
        while (rx_q.size() != 0 || s_valid || chans_q.size() != 0 || m_valid)
            @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // one frame of random content; len below the full length cuts it short
    task automatic queue_frame(input int len, input logic bad_end);
        int             style;
        sfd_pkg::byte_t b;
        style = $urandom_range(9);
        rx_q.push_back(start_byte_q);
        for (int i = 1; i < len; i++) begin
            case (style)
                0:       b = 8'h00;
                1:       b = 8'hFF;
                default: b = sfd_pkg::byte_t'($urandom_range(255));
            endcase
            if (i == sfd_pkg::FRAME_LEN - 1) begin
                if (bad_end)
                    b[3:0] = 4'(sfd_pkg::END_NIBBLE + 4'($urandom_range(1, 15)));
                else
                    b[3:0] = sfd_pkg::END_NIBBLE;
            end
            rx_q.push_back(b);
        end
    endtask

    task automatic queue_random_frames(input int count);
        int n;
        for (int f = 0; f < count; f++) begin
            // noise between frames, ignored while idle unless it hits the start byte
            n = $urandom_range(2);
            repeat (n) rx_q.push_back(sfd_pkg::byte_t'($urandom_range(255)));
            if ($urandom_range(99) < 10)
                queue_frame($urandom_range(2, sfd_pkg::FRAME_LEN - 1), 1'b0);
            else
                queue_frame(sfd_pkg::FRAME_LEN, $urandom_range(99) < 15);
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: noise, then a frame of ones carrying the start byte as data
        set_idling(0, 0);
        rx_q.push_back(8'h00);
        rx_q.push_back(8'hFF);
        rx_q.push_back(sfd_pkg::START_BYTE_RESET);
        for (int i = 1; i < sfd_pkg::FRAME_LEN - 1; i++)
            rx_q.push_back((i == 3 || i == 12) ? sfd_pkg::START_BYTE_RESET : 8'hFF);
        rx_q.push_back(8'hF4);
        drain();

        write_start_byte(8'h00);
        queue_random_frames(12);
        drain();

        write_start_byte(8'hFF);
        set_idling(59, 0);
        queue_random_frames(12);
        drain();

        write_start_byte(sfd_pkg::byte_t'($urandom_range(255)));
        set_idling(0, 59);
        queue_random_frames(12);
        drain();

        write_start_byte(sfd_pkg::START_BYTE_RESET);
        set_idling(26, 26);
        queue_random_frames(12);
        drain();

        // receiver held off while the sender keeps offering whole frames
        set_idling(0, 0);
        hold_req <= 1'b1;
        for (int f = 0; f < 6; f++)
            queue_frame(sfd_pkg::FRAME_LEN, 1'b0);
        drain();

        repeat (8) @(posedge aclk);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
